// ===== hdl/tsc_pkg.sv =====
// shared types and constants for the per-port tcp syn counter
// no dependencies
`timescale 1ns / 1ps

package tsc_pkg;

	localparam int PORT_COUNT  = 65536;
	localparam int COUNT_WIDTH = 32;
	localparam int PORT_W      = 16;
	localparam int PORT_AW     = $clog2(PORT_COUNT);
	localparam int APB_AW      = 2;

	localparam logic [APB_AW-1:0]      REG_THRESHOLD   = 2'd0;
	localparam logic [COUNT_WIDTH-1:0] THRESHOLD_RESET = COUNT_WIDTH'(100);

	typedef struct packed {
		logic [COUNT_WIDTH-1:0] syn;
		logic [COUNT_WIDTH-1:0] synack;
		logic [COUNT_WIDTH-1:0] unans;
	} row_t;

	typedef struct packed {
		logic dhit;
		logic shit;
		logic same;
	} upd_ctl_t;

endpackage

// ===== hdl/tsc_ram.sv =====
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`timescale 1ns / 1ps

module tsc_ram #(
	parameter int Width = 32,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/tsc_update.sv =====
// read-modify-write datapath: saturating bumps and unanswered refresh of two rows
// depends on tsc_pkg
`timescale 1ns / 1ps

module tsc_update
	import tsc_pkg::*;
(
	input  upd_ctl_t ctl,
	input  row_t     row_d,
	input  row_t     row_s,
	output row_t     new_d,
	output row_t     new_s
);

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		return (&v) ? v : v + COUNT_WIDTH'(1);
	endfunction

	function automatic row_t bump(input row_t r, input logic inc_syn, input logic inc_ack,
	                              input logic refresh);
		row_t o;
		o.syn    = inc_syn ? sat_inc(r.syn) : r.syn;
		o.synack = inc_ack ? sat_inc(r.synack) : r.synack;
		o.unans  = (refresh && o.syn >= o.synack) ? o.syn - o.synack : r.unans;
		return o;
	endfunction

	row_t s_alone;

	always_comb begin
		new_d   = bump(row_d, ctl.dhit, ctl.same & ctl.shit, ctl.dhit);
		s_alone = bump(row_s, 1'b0, ctl.shit, ctl.shit);
		new_s   = ctl.same ? new_d : s_alone;
	end

endmodule

// ===== hdl/tsc_cfg.sv =====
// apb register file holding the report threshold
// depends on tsc_pkg
`timescale 1ns / 1ps

module tsc_cfg
	import tsc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_AW-1:0]      paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	output logic [COUNT_WIDTH-1:0] threshold
);

	logic [COUNT_WIDTH-1:0] threshold_q;

	assign pready    = 1'b1;
	assign threshold = threshold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (psel && penable && pwrite && pready && paddr == REG_THRESHOLD) begin
			threshold_q <= pwdata[COUNT_WIDTH-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == REG_THRESHOLD) begin
			prdata = 32'(threshold_q);
		end
	end

endmodule

// ===== hdl/tcp_syn_scan_port_counter_core.sv =====
// top level: sequencer around the per-port count table, query results, config port
// depends on tsc_pkg, tsc_ram, tsc_update, tsc_cfg
`timescale 1ns / 1ps

// After reset the block clears its count table, one port entry per cycle, with
// busy high; configuration writes are taken meanwhile. Items are taken when
// start is high and busy low. A packet is accepted with the destination row
// read, then holds busy high for the source row read, the destination row write
// and the source row write on the single table write port; a packet that bumps
// no counter leaves busy low. A query's result appears with result_valid for one
// cycle, registered out of the query state, and cannot be held off.

module tcp_syn_scan_port_counter_core
	import tsc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   req_type,
	input  logic                   has_tcp,
	input  logic [PORT_W-1:0]      dest_port,
	input  logic [PORT_W-1:0]      src_port,
	input  logic                   syn_flag,
	input  logic                   ack_flag,
	input  logic [PORT_W-1:0]      query_port,
	output logic                   result_valid,
	output logic [PORT_W-1:0]      port_number,
	output logic [COUNT_WIDTH-1:0] syn_total,
	output logic [COUNT_WIDTH-1:0] unanswered_total,
	output logic                   over_threshold,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_AW-1:0]      paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_RD_S = 3'd2;
	localparam logic [2:0] ST_WR_D = 3'd3;
	localparam logic [2:0] ST_WR_S = 3'd4;
	localparam logic [2:0] ST_QRY  = 3'd5;

	localparam logic [PORT_AW-1:0] LAST_ENTRY = PORT_AW'(PORT_COUNT - 1);

	function automatic logic counted(input logic [PORT_W-1:0] p);
		return p != '0 && {1'b0, p} < (PORT_W + 1)'(PORT_COUNT);
	endfunction

	logic [2:0]             state_q;
	logic [PORT_AW-1:0]     clr_q;
	logic [PORT_AW-1:0]     dport_q;
	logic [PORT_AW-1:0]     sport_q;
	logic [PORT_W-1:0]      qport_q;
	logic                   qcounted_q;
	upd_ctl_t               ctl_q;
	row_t                   row_d_q;
	row_t                   new_s_q;
	row_t                   new_d;
	row_t                   new_s;
	row_t                   rd_row;
	logic                   accept;
	logic                   dhit;
	logic                   shit;
	logic                   ram_we;
	logic [PORT_AW-1:0]     ram_waddr;
	row_t                   ram_wdata;
	logic [PORT_AW-1:0]     ram_raddr;
	logic [COUNT_WIDTH-1:0] threshold;
	logic [COUNT_WIDTH-1:0] q_syn;
	logic [COUNT_WIDTH-1:0] q_unans;

	logic                   result_valid_q;
	logic [PORT_W-1:0]      port_number_q;
	logic [COUNT_WIDTH-1:0] syn_total_q;
	logic [COUNT_WIDTH-1:0] unanswered_total_q;
	logic                   over_threshold_q;

	assign busy   = state_q != ST_IDLE;
	assign accept = start && !busy;
	assign dhit   = has_tcp && syn_flag && counted(dest_port);
	assign shit   = has_tcp && syn_flag && ack_flag && counted(src_port);

	tsc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.threshold (threshold)
	);

	tsc_ram #(
		.Width ($bits(row_t)),
		.Depth (PORT_COUNT)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rd_row)
	);

	tsc_update u_update (
		.ctl   (ctl_q),
		.row_d (row_d_q),
		.row_s (rd_row),
		.new_d (new_d),
		.new_s (new_s)
	);

	always_comb begin
		ram_raddr = sport_q;
		if (state_q == ST_IDLE) begin
			ram_raddr = req_type ? query_port[PORT_AW-1:0] : dest_port[PORT_AW-1:0];
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = sport_q;
		ram_wdata = new_s_q;
		unique case (state_q)
			ST_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_WR_D: begin
				ram_we    = ctl_q.dhit;
				ram_waddr = dport_q;
				ram_wdata = new_d;
			end
			ST_WR_S: begin
				ram_we = ctl_q.shit;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLR;
			clr_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + PORT_AW'(1);
					if (clr_q == LAST_ENTRY) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (req_type) begin
							state_q <= ST_QRY;
						end else if (dhit || shit) begin
							state_q <= ST_RD_S;
						end
					end
				end
				ST_RD_S: state_q <= ST_WR_D;
				ST_WR_D: state_q <= ST_WR_S;
				ST_WR_S: state_q <= ST_IDLE;
				ST_QRY: begin
					result_valid_q <= 1'b1;
					state_q        <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dport_q    <= dest_port[PORT_AW-1:0];
			sport_q    <= src_port[PORT_AW-1:0];
			qport_q    <= query_port;
			qcounted_q <= counted(query_port);
			ctl_q.dhit <= dhit;
			ctl_q.shit <= shit;
			ctl_q.same <= dest_port == src_port;
		end
		if (state_q == ST_RD_S) begin
			row_d_q <= rd_row;
		end
		if (state_q == ST_WR_D) begin
			new_s_q <= new_s;
		end
	end

	assign q_syn   = qcounted_q ? rd_row.syn : '0;
	assign q_unans = qcounted_q ? rd_row.unans : '0;

	always_ff @(posedge clk) begin
		if (state_q == ST_QRY) begin
			port_number_q      <= qport_q;
			syn_total_q        <= q_syn;
			unanswered_total_q <= q_unans;
			over_threshold_q   <= q_syn >= threshold;
		end
	end

	assign result_valid     = result_valid_q;
	assign port_number      = port_number_q;
	assign syn_total        = syn_total_q;
	assign unanswered_total = unanswered_total_q;
	assign over_threshold   = over_threshold_q;

`ifndef SYNTH
	a_query_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_QRY |=> result_valid)
		else $error("query did not produce a result");

	a_result_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q) == ST_QRY)
		else $error("result without a query");

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLR |-> ram_we && ram_wdata == '0)
		else $error("clearing pass wrote nonzero data");

	a_query_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req_type |=> state_q == ST_QRY)
		else $error("accepted query not sequenced");
`endif

endmodule

// ===== test/tb.sv =====
// self-checking testbench for tcp_syn_scan_port_counter_core: directed table, then random phases
// per-port syn / syn-ack / unanswered counts predicted in the bench and compared per query result
// depends on tsc_pkg and the core rtl
`timescale 1ns / 1ps

module tb;
	import tsc_pkg::*;

	localparam int   HALF_PERIOD   = 2;
	localparam int   CYCLE_LIMIT   = 400000;
	localparam int   SETTLE_CYCLES = 8;
	localparam int   PHASES        = 6;
	localparam int   PHASE_ITEMS   = 190;
	localparam int   ERR_PRINT_MAX = 40;
	localparam logic REQ_PACKET    = 1'b0;
	localparam logic REQ_QUERY     = 1'b1;

	typedef enum logic [1:0] {ROW_ITEM, ROW_CHECK, ROW_THRESH} row_kind_t;

	typedef struct packed {
		logic              req;
		logic              tcp;
		logic [PORT_W-1:0] dport;
		logic [PORT_W-1:0] sport;
		logic              syn;
		logic              ack;
		logic [PORT_W-1:0] qport;
	} scan_item_t;

	typedef struct packed {
		logic [PORT_W-1:0]      port;
		logic [COUNT_WIDTH-1:0] syn;
		logic [COUNT_WIDTH-1:0] open;
		logic                   over;
	} port_report_t;

	// num: threshold on a threshold row, syn total on a check row
	typedef struct packed {
		row_kind_t              kind;
		logic                   req;
		logic                   tcp;
		logic                   syn;
		logic                   ack;
		logic [PORT_W-1:0]      dport;
		logic [PORT_W-1:0]      sport;
		logic [PORT_W-1:0]      qport;
		logic [COUNT_WIDTH-1:0] num;
		logic [COUNT_WIDTH-1:0] open;
		logic                   over;
	} stim_row_t;

	localparam stim_row_t DIRECTED [25] = '{
		'{ROW_CHECK,  REQ_QUERY,  0, 0, 0, 0,     0, 0,     0, 0, 0},
		'{ROW_CHECK,  REQ_QUERY,  0, 0, 0, 0,     0, 65535, 0, 0, 0},
		'{ROW_CHECK,  REQ_QUERY,  0, 0, 0, 0,     0, 1,     0, 0, 0},
		'{ROW_ITEM,   REQ_PACKET, 1, 1, 1, 0,     0, 0,     0, 0, 0},
		'{ROW_CHECK,  REQ_QUERY,  0, 0, 0, 0,     0, 0,     0, 0, 0},
		'{ROW_ITEM,   REQ_PACKET, 0, 1, 1, 5,     5, 0,     0, 0, 0},
		'{ROW_CHECK,  REQ_QUERY,  0, 0, 0, 0,     0, 5,     0, 0, 0},
		'{ROW_ITEM,   REQ_PACKET, 1, 1, 0, 65535, 1, 0,     0, 0, 0},
		'{ROW_CHECK,  REQ_QUERY,  0, 0, 0, 0,     0, 65535, 1, 1, 0},
		'{ROW_ITEM,   REQ_PACKET, 1, 1, 1, 7,     7, 0,     0, 0, 0},
		'{ROW_CHECK,  REQ_QUERY,  0, 0, 0, 0,     0, 7,     1, 0, 0},
		'{ROW_ITEM,   REQ_PACKET, 1, 1, 1, 2,     3, 0,     0, 0, 0},
		'{ROW_CHECK,  REQ_QUERY,  0, 0, 0, 0,     0, 3,     0, 0, 0},
		'{ROW_CHECK,  REQ_QUERY,  0, 0, 0, 0,     0, 2,     1, 1, 0},
		'{ROW_ITEM,   REQ_PACKET, 1, 0, 1, 2,     3, 0,     0, 0, 0},
		'{ROW_ITEM,   REQ_PACKET, 1, 1, 1, 3,     2, 0,     0, 0, 0},
		'{ROW_ITEM,   REQ_QUERY,  0, 0, 0, 0,     0, 3,     0, 0, 0},
		'{ROW_ITEM,   REQ_QUERY,  0, 0, 0, 0,     0, 2,     0, 0, 0},
		'{ROW_THRESH, REQ_QUERY,  0, 0, 0, 0,     0, 0,     0, 0, 0},
		'{ROW_CHECK,  REQ_QUERY,  0, 0, 0, 0,     0, 0,     0, 0, 1},
		'{ROW_CHECK,  REQ_QUERY,  0, 0, 0, 0,     0, 65535, 1, 1, 1},
		'{ROW_THRESH, REQ_QUERY,  0, 0, 0, 0,     0, 0,     32'hFFFF_FFFF, 0, 0},
		'{ROW_CHECK,  REQ_QUERY,  0, 0, 0, 0,     0, 65535, 1, 1, 0},
		'{ROW_THRESH, REQ_QUERY,  0, 0, 0, 0,     0, 0,     1, 0, 0},
		'{ROW_ITEM,   REQ_QUERY,  0, 0, 0, 0,     0, 7,     0, 0, 0}
	};

	localparam logic [PORT_W-1:0] HOT_PORTS [8] = '{0, 1, 2, 7, 443, 8080, 32768, 65535};
	localparam logic [PORT_W-1:0] BUSY_PORT     = 80;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic                   req_type;
	logic                   has_tcp;
	logic [PORT_W-1:0]      dest_port;
	logic [PORT_W-1:0]      src_port;
	logic                   syn_flag;
	logic                   ack_flag;
	logic [PORT_W-1:0]      query_port;
	logic                   result_valid;
	logic [PORT_W-1:0]      port_number;
	logic [COUNT_WIDTH-1:0] syn_total;
	logic [COUNT_WIDTH-1:0] unanswered_total;
	logic                   over_threshold;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [APB_AW-1:0]      paddr;
	logic [31:0]            pwdata;
	logic [31:0]            prdata;
	logic                   pready;

	logic                   typed_row;
	port_report_t           typed_want;

	bit [COUNT_WIDTH-1:0]   syn_seen    [PORT_COUNT];
	bit [COUNT_WIDTH-1:0]   synack_seen [PORT_COUNT];
	bit [COUNT_WIDTH-1:0]   open_syns   [PORT_COUNT];
	logic [COUNT_WIDTH-1:0] thresh = THRESHOLD_RESET;
	port_report_t           expected_reports [$];
	int                     errors = 0;
	int                     cycles = 0;

	tcp_syn_scan_port_counter_core u_top (.*);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (errors < ERR_PRINT_MAX)
			$display("%0t: %s got %0h want %0h", $realtime, what, got, want);
		errors++;
	endtask

	function automatic bit counted(logic [PORT_W-1:0] p);
		return p != 0 && int'(p) < PORT_COUNT;
	endfunction

	function automatic logic [COUNT_WIDTH-1:0] bump(logic [COUNT_WIDTH-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic void settle_open(logic [PORT_W-1:0] p);
		if (syn_seen[p] >= synack_seen[p])
			open_syns[p] = syn_seen[p] - synack_seen[p];
	endfunction

	// applies one accepted item to the count tables; returns 1 when it yields a report
	function automatic bit tally_item(input scan_item_t it, output port_report_t rep);
		bit hit_d;
		bit hit_s;
		rep = '0;
		if (it.req == REQ_QUERY) begin
			rep.port = it.qport;
			if (counted(it.qport)) begin
				rep.syn  = syn_seen[it.qport];
				rep.open = open_syns[it.qport];
			end
			rep.over = rep.syn >= thresh;
			return 1'b1;
		end
		hit_d = it.tcp && it.syn && counted(it.dport);
		hit_s = it.tcp && it.syn && it.ack && counted(it.sport);
		if (hit_d)
			syn_seen[it.dport] = bump(syn_seen[it.dport]);
		if (hit_s)
			synack_seen[it.sport] = bump(synack_seen[it.sport]);
		if (hit_d)
			settle_open(it.dport);
		if (hit_s)
			settle_open(it.sport);
		return 1'b0;
	endfunction

	always @(posedge clk) begin : track
		scan_item_t   seen;
		port_report_t want;
		if (result_valid === 1'b1) begin
			if (expected_reports.size() == 0) begin
				flag_mismatch("unexpected result, port", 32'(port_number), 32'd0);
			end else begin
				want = expected_reports.pop_front();
				if (port_number !== want.port)
					flag_mismatch("port_number", 32'(port_number), 32'(want.port));
				if (syn_total !== want.syn)
					flag_mismatch("syn_total", syn_total, want.syn);
				if (unanswered_total !== want.open)
					flag_mismatch("unanswered_total", unanswered_total, want.open);
				if (over_threshold !== want.over)
					flag_mismatch("over_threshold", 32'(over_threshold), 32'(want.over));
			end
		end
		if (psel && penable && pwrite && pready && paddr == REG_THRESHOLD)
			thresh = pwdata;
		if (start && busy === 1'b0) begin
			seen = '{req_type, has_tcp, dest_port, src_port, syn_flag, ack_flag, query_port};
			if (tally_item(seen, want))
				expected_reports.push_back(typed_row ? typed_want : want);
		end
	end

	// leaves start high after the transfer so a back-to-back item needs no toggle
	task automatic offer_item(scan_item_t it, logic typed, port_report_t want);
		start      <= 1'b1;
		req_type   <= it.req;
		has_tcp    <= it.tcp;
		dest_port  <= it.dport;
		src_port   <= it.sport;
		syn_flag   <= it.syn;
		ack_flag   <= it.ack;
		query_port <= it.qport;
		typed_row  <= typed;
		typed_want <= want;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (expected_reports.size() != 0 || busy !== 1'b0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_threshold(logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_THRESHOLD;
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== v)
			flag_mismatch("threshold readback", prdata, v);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [PORT_W-1:0] pick_port();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return BUSY_PORT;
		if (r < 70)
			return HOT_PORTS[$urandom_range(0, 7)];
		return PORT_W'($urandom);
	endfunction

	initial begin
		stim_row_t              row;
		scan_item_t             it;
		port_report_t           want;
		logic [COUNT_WIDTH-1:0] thr_plan [PHASES];
		int                     burst_left;
		int                     gap;

		start      <= 1'b0;
		req_type   <= REQ_PACKET;
		has_tcp    <= 1'b0;
		dest_port  <= '0;
		src_port   <= '0;
		syn_flag   <= 1'b0;
		ack_flag   <= 1'b0;
		query_port <= '0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= REG_THRESHOLD;
		pwdata     <= '0;
		typed_row  <= 1'b0;
		typed_want <= '0;
		arst_n     <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i]) begin
			row = DIRECTED[i];
			if (row.kind == ROW_THRESH) begin
				drain();
				set_threshold(row.num);
			end else begin
				it   = '{row.req, row.tcp, row.dport, row.sport, row.syn, row.ack, row.qport};
				want = '{row.qport, row.num, row.open, row.over};
				offer_item(it, row.kind == ROW_CHECK, want);
			end
		end

		thr_plan   = '{THRESHOLD_RESET, 0, 32'hFFFF_FFFF, 0, 0, 60};
		thr_plan[3] = $urandom_range(1, 40);
		thr_plan[4] = $urandom;
		burst_left = 0;
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			set_threshold(thr_plan[ph]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
					if (gap != 0) begin
						start <= 1'b0;
						repeat (gap) @(posedge clk);
					end
				end
				burst_left--;
				it.req   = ($urandom_range(0, 99) < 25) ? REQ_QUERY : REQ_PACKET;
				it.tcp   = $urandom_range(0, 9) != 0;
				it.syn   = $urandom_range(0, 9) < 7;
				it.ack   = $urandom_range(0, 9) < 6;
				it.dport = pick_port();
				it.sport = pick_port();
				it.qport = pick_port();
				offer_item(it, 1'b0, '0);
			end
		end

		drain();
		if (errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
